// File: rtl/core/bpa_pkg.sv
// bpa_pkg: shared constants, action codes and controller/datapath structs
// for the bitmap page allocator; no dependencies
`default_nettype none

package bpa_pkg;

    localparam int DEFAULT_BITMAP_BYTES = 4096;

    // page numbers and byte numbers are bounded by the 13-bit active_bytes register
    localparam int CFG_W  = 13;
    localparam int BYTE_W = 13;
    localparam int PAGE_W = 16;
    localparam int IDX_W  = 15;
    localparam int CNT_W  = 16;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 13'd4096;
    localparam logic [7:0]       FULL_BYTE    = 8'hFF;

    localparam logic [1:0] ACT_ALLOC_ONE = 2'd0;
    localparam logic [1:0] ACT_ALLOC_RUN = 2'd1;
    localparam logic [1:0] ACT_MARK      = 2'd2;
    localparam logic [1:0] ACT_FREE      = 2'd3;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic scan_start;
        logic scan_run;
        logic write_start;
        logic write_run;
        logic load_out;
        logic out_ok;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic early_fail;
        logic is_scan;
        logic is_run;
        logic found;
        logic scan_end;
        logic write_end;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/bpa_ram.sv
// bpa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bpa_datapath.sv
// bpa_datapath: request registers, byte scan/update pipeline, bitmap ram,
// result registers; depends on bpa_pkg and bpa_ram
`default_nettype none

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int BITMAP_BYTES = DEFAULT_BITMAP_BYTES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire logic [BYTE_W-1:0]  live_bytes,
    input  wire logic [1:0]         action,
    input  wire logic [IDX_W-1:0]   start_page,
    input  wire logic [CNT_W-1:0]   req_pages,
    output logic                    ok,
    output logic      [IDX_W-1:0]   grant_page
);

    localparam int ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int CLR_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES + 1) : 1;

    logic [1:0]        act_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [BYTE_W-1:0] issue_ptr_reg, issue_ptr_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic              issuing_reg, issuing_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [BYTE_W-1:0] ev_addr_reg, ev_addr_next;
    logic [PAGE_W-1:0] run_reg, run_next;
    logic [PAGE_W-1:0] first_reg, first_next;
    logic [PAGE_W-1:0] where_reg;
    logic [PAGE_W-1:0] rf_reg, rl_reg;

    logic [PAGE_W-1:0] total_pages;
    logic [PAGE_W:0]   range_end;
    logic [PAGE_W-1:0] rng_first, rng_last;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic [2:0]        zero_bit;
    logic              one_hit;
    logic              run_hit;
    logic [PAGE_W-1:0] run_first;
    logic [PAGE_W-1:0] page_base;
    logic [7:0]        wr_mask;
    logic [7:0]        upd_byte;

    logic              st_scan;
    logic              st_run;
    logic              st_early_fail;
    logic              hit_now;
    logic              found_now;
    logic              at_last;

    assign total_pages = {live_bytes, 3'b000};
    assign range_end   = {2'b00, start_reg} + {1'b0, count_reg};
    assign page_base   = {ev_addr_reg, 3'b000};

    // request checks that fail without touching the bitmap
    always_comb
    begin
        st_scan = (act_reg == ACT_ALLOC_ONE) || (act_reg == ACT_ALLOC_RUN);
        st_run  = (act_reg == ACT_ALLOC_RUN);
        if (st_scan)
        begin
            st_early_fail = (live_bytes == '0)
                || ((act_reg == ACT_ALLOC_RUN) && (count_reg == '0));
        end
        else
        begin
            st_early_fail = (count_reg == '0) || (range_end > {1'b0, total_pages});
        end
    end

    // lowest free page of one byte
    always_comb
    begin
        zero_bit = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!ram_rdata[i])
            begin
                zero_bit = 3'(i);
            end
        end
        one_hit = (ram_rdata != FULL_BYTE);
    end

    // free-run tracking across the eight pages of one byte
    always_comb
    begin
        logic [PAGE_W-1:0] r;
        logic [PAGE_W-1:0] f;
        logic              h;
        logic [PAGE_W-1:0] hf;
        r  = run_reg;
        f  = first_reg;
        h  = 1'b0;
        hf = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (ram_rdata[i])
            begin
                r = '0;
            end
            else
            begin
                if (r == '0)
                begin
                    f = page_base | PAGE_W'(i);
                end
                r = r + 1'b1;
                if ((r == count_reg) && !h)
                begin
                    h  = 1'b1;
                    hf = f;
                end
            end
        end
        run_next  = r;
        first_next = f;
        run_hit   = h;
        run_first = hf;
    end

    // page mask of the current byte during a range update
    always_comb
    begin
        logic [2:0] lo;
        logic [2:0] hi;
        lo = (ev_addr_reg == rf_reg[PAGE_W-1:3]) ? rf_reg[2:0] : 3'd0;
        hi = (ev_addr_reg == rl_reg[PAGE_W-1:3]) ? rl_reg[2:0] : 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            wr_mask[i] = (3'(i) >= lo) && (3'(i) <= hi);
        end
        upd_byte = (act_reg == ACT_FREE) ? (ram_rdata & ~wr_mask) : (ram_rdata | wr_mask);
    end

    // status flags come from registers and ram data only; the sequencer
    // looks at each one only in the state it belongs to
    assign hit_now   = ev_valid_reg && ((act_reg == ACT_ALLOC_ONE) ? one_hit : run_hit);
    assign found_now = cmd.scan_run && hit_now;
    assign at_last   = ev_valid_reg && (ev_addr_reg == last_reg);

    assign status = '{
        clear_done: (clr_cnt_reg == CLR_W'(BITMAP_BYTES)),
        early_fail: st_early_fail,
        is_scan:    st_scan,
        is_run:     st_run,
        found:      hit_now,
        scan_end:   at_last && !hit_now,
        write_end:  at_last
    };

    assign rng_first = st_run ? where_reg : {1'b0, start_reg};
    assign rng_last  = rng_first + count_reg - 1'b1;

    // ram ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(ev_addr_reg);
        ram_wdata = upd_byte;
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[ADDR_W-1:0];
            ram_wdata = '0;
        end
        else if (found_now && (act_reg == ACT_ALLOC_ONE))
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (8'd1 << zero_bit);
        end
        else if (cmd.write_run && ev_valid_reg)
        begin
            ram_we = 1'b1;
        end
        ram_re    = (cmd.scan_run || cmd.write_run) && issuing_reg;
        ram_raddr = ADDR_W'(issue_ptr_reg);
    end

    // read-issue and evaluate pointers
    always_comb
    begin
        clr_cnt_next   = cmd.clear_step ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        issue_ptr_next = issue_ptr_reg;
        last_next      = last_reg;
        issuing_next   = issuing_reg;
        ev_valid_next  = ev_valid_reg;
        ev_addr_next   = ev_addr_reg;
        if (cmd.scan_start)
        begin
            issue_ptr_next = '0;
            last_next      = live_bytes - 1'b1;
            issuing_next   = 1'b1;
            ev_valid_next  = 1'b0;
        end
        else if (cmd.write_start)
        begin
            issue_ptr_next = rng_first[PAGE_W-1:3];
            last_next      = rng_last[PAGE_W-1:3];
            issuing_next   = 1'b1;
            ev_valid_next  = 1'b0;
        end
        else if (cmd.scan_run || cmd.write_run)
        begin
            ev_valid_next = ram_re;
            ev_addr_next  = issue_ptr_reg;
            if (ram_re)
            begin
                issuing_next   = (issue_ptr_reg != last_reg);
                issue_ptr_next = issue_ptr_reg + 1'b1;
            end
            if (found_now)
            begin
                issuing_next  = 1'b0;
                ev_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            issuing_reg  <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            issuing_reg  <= issuing_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_ptr_reg <= issue_ptr_next;
        last_reg      <= last_next;
        ev_addr_reg   <= ev_addr_next;
        if (cmd.load_req)
        begin
            act_reg   <= action;
            start_reg <= start_page;
            count_reg <= req_pages;
        end
        if (cmd.scan_start)
        begin
            run_reg   <= '0;
            first_reg <= '0;
        end
        else if (cmd.scan_run && ev_valid_reg)
        begin
            run_reg   <= run_next;
            first_reg <= first_next;
        end
        if (found_now)
        begin
            where_reg <= (act_reg == ACT_ALLOC_ONE) ? (page_base | PAGE_W'(zero_bit)) : run_first;
        end
        if (cmd.write_start)
        begin
            rf_reg <= rng_first;
            rl_reg <= rng_last;
        end
        if (cmd.load_out)
        begin
            ok         <= cmd.out_ok;
            grant_page <= (cmd.out_ok && st_scan) ? where_reg[IDX_W-1:0] : '0;
        end
    end

    bpa_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/bpa_ctrl.sv
// bpa_ctrl: request sequencer for the bitmap page allocator
// depends on bpa_pkg
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_WSETUP = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ok_reg, ok_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        cmd.out_ok = ok_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = !status.clear_done;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (status.early_fail)
                begin
                    ok_next    = 1'b0;
                    state_next = S_FINISH;
                end
                else if (status.is_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_WSETUP;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.found)
                begin
                    ok_next    = 1'b1;
                    state_next = status.is_run ? S_WSETUP : S_FINISH;
                end
                else if (status.scan_end)
                begin
                    ok_next    = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_WSETUP:
            begin
                cmd.write_start = 1'b1;
                state_next      = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_run = 1'b1;
                if (status.write_end)
                begin
                    ok_next    = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bitmap_page_allocator.sv
// bitmap_page_allocator: top level, config register, sequencer and datapath
// depends on bpa_pkg, bpa_ctrl, bpa_datapath (and bpa_ram below it)
//
//  channel   direction  handshake             beat contents
//  in        sink       in_valid / in_ready   action, start_page, req_pages
//  out       source     out_valid / out_ready ok, grant_page
//  cfg       sink       cfg_wr_en             cfg_wr_data (active_bytes)
//
// after reset a clearing pass zeroes the bitmap, one byte per cycle, over all
// BITMAP_BYTES bytes; in_ready stays low until it ends (cfg writes still taken)
// one request at a time; the bitmap ram reads and writes one byte per cycle
// take one page / take a run: bytes are scanned from byte zero to the first hit,
// at most active_bytes of them, and a run adds an update pass over the bytes it covers
// mark / free range: an update pass over the bytes covered by the range
// a result waits in the output register; the next request is accepted meanwhile
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int BITMAP_BYTES = DEFAULT_BITMAP_BYTES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [IDX_W-1:0]  start_page,
    input  wire logic [CNT_W-1:0]  req_pages,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   ok,
    output logic      [IDX_W-1:0]  grant_page
);

    logic [CFG_W-1:0]  active_bytes_reg;
    logic [BYTE_W-1:0] live_bytes;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // active byte count register; user must write only while idle, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bytes_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_bytes_reg <= cfg_wr_data;
        end
    end

    // bytes beyond the physical bitmap are not there
    assign live_bytes = (32'(active_bytes_reg) > BITMAP_BYTES)
        ? BYTE_W'(BITMAP_BYTES) : BYTE_W'(active_bytes_reg);

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    bpa_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .live_bytes (live_bytes),
        .action     (action),
        .start_page (start_page),
        .req_pages  (req_pages),
        .ok         (ok),
        .grant_page (grant_page)
    );

    // a failed result always reports page zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (grant_page == '0))
        else $error("failed result with nonzero page index");

    // one request in flight: ready drops right after an accepted beat
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // an allocated page lies inside the active bitmap
    a_page_live: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok) |-> ({1'b0, grant_page} < {live_bytes, 3'b000}))
        else $error("allocated page outside the active bitmap");

endmodule

`default_nettype wire

// File: verif/page_grant_check.sv
`timescale 1ns / 1ps
// page_grant_check: passive monitor for the bitmap page allocator that predicts
// every result beat from its own copy of the page bitmap and compares it
// depends on bpa_pkg (widths, action codes, active_bytes reset value)
module page_grant_check
    import bpa_pkg::*;
#(
    parameter int BITMAP_BYTES = DEFAULT_BITMAP_BYTES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [IDX_W-1:0]  start_page,
    input  wire logic [CNT_W-1:0]  req_pages,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              ok,
    input  wire logic [IDX_W-1:0]  grant_page,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] grant_page;
    } grant_t;

    logic [7:0]       page_map [BITMAP_BYTES];
    logic [CFG_W-1:0] live_bytes;
    grant_t           grants_due [$];
    grant_t           want;
    int               mismatches = 0;

    function automatic void set_pages(int first, int cnt, logic used);
        for (int p = first; p < first + cnt; p++)
            page_map[p >> 3][p & 7] = used;
    endfunction

    // one request against the private bitmap copy; updates it and returns the grant
    function automatic grant_t serve_request(logic [1:0] act, logic [IDX_W-1:0] first_pg,
                                             logic [CNT_W-1:0] cnt);
        grant_t g;
        int     live;
        int     run;
        int     run_start;
        g = '{ok: 1'b0, grant_page: '0};
        live = ((live_bytes > BITMAP_BYTES) ? BITMAP_BYTES : int'(live_bytes)) * 8;
        run = 0;
        run_start = 0;
        case (act)
            ACT_ALLOC_ONE: begin
                for (int p = 0; p < live; p++) begin
                    if (!page_map[p >> 3][p & 7]) begin
                        page_map[p >> 3][p & 7] = 1'b1;
                        g.ok = 1'b1;
                        g.grant_page = p[IDX_W-1:0];
                        break;
                    end
                end
            end
            ACT_ALLOC_RUN: begin
                if (cnt != 0) begin
                    for (int p = 0; p < live; p++) begin
                        if (page_map[p >> 3][p & 7]) begin
                            run = 0;
                        end else begin
                            if (run == 0)
                                run_start = p;
                            run++;
                            if (run == int'(cnt)) begin
                                set_pages(run_start, run, 1'b1);
                                g.ok = 1'b1;
                                g.grant_page = run_start[IDX_W-1:0];
                                break;
                            end
                        end
                    end
                end
            end
            default: begin
                if (cnt != 0 && int'(first_pg) + int'(cnt) <= live) begin
                    set_pages(int'(first_pg), int'(cnt), act == ACT_MARK);
                    g.ok = 1'b1;
                end
            end
        endcase
        return g;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < BITMAP_BYTES; i++)
                page_map[i] = 8'h00;
            live_bytes = ACTIVE_RESET;
            grants_due.delete();
        end else begin
            if (cfg_wr_en)
                live_bytes = cfg_wr_data;
            // result first: a request taken at this edge cannot answer at this edge
            if (out_valid && out_ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual ok=%0d grant_page=%0d",
                             $time, ok, grant_page);
                    mismatches++;
                end else begin
                    want = grants_due.pop_front();
                    if (ok !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0d, actual %0d",
                                 $time, want.ok, ok);
                        mismatches++;
                    end
                    if (grant_page !== want.grant_page) begin
                        $display("%0t: grant_page mismatch, expected %0d, actual %0d",
                                 $time, want.grant_page, grant_page);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                grants_due.push_back(serve_request(action, start_page, req_pages));
        end
        fail_count  <= mismatches;
        outstanding <= grants_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the bitmap page allocator
// depends on bpa_pkg, bitmap_page_allocator and page_grant_check
module tb_top;
    import bpa_pkg::*;

    // cycles to let pass once nothing is expected, to catch stray result beats
    localparam int TAIL_CYCLES  = 64;
    // one long receiver hold-off so the output register fills and in_ready drops
    localparam int HOLD_AT_BEAT = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 18;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [1:0]       action      = ACT_ALLOC_ONE;
    logic [IDX_W-1:0] start_page  = '0;
    logic [CNT_W-1:0] req_pages   = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic             ok;
    logic [IDX_W-1:0] grant_page;

    int fail_count;
    int outstanding;
    int beats_taken = 0;
    // remaining beats of a no-idle stretch, one per side
    int send_calm   = 0;
    int take_calm   = 0;

    // active_bytes per phase; -1 picks a fresh small value at random
    // the large settings get few beats since their scans are long
    int plan_bytes [PHASES] = '{1, 2, 3, 16, -1, 7, 64, 4096, 8, 0, -1, 33, 8191, 1, -1,
                                128, 5000, -1};
    int plan_items [PHASES] = '{60, 80, 80, 100, 60, 80, 100, 25, 100, 15, 60, 100, 25,
                                50, 60, 80, 20, 60};

    always #5 clk = ~clk;

    bitmap_page_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .start_page  (start_page),
        .req_pages   (req_pages),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .grant_page  (grant_page)
    );

    page_grant_check grant_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .start_page  (start_page),
        .req_pages   (req_pages),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .grant_page  (grant_page),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // random idle gap before the next beat, with runs of back-to-back beats
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    // offer one request beat and hold it until taken
    // inputs change on the falling edge; acceptance is seen at the rising edge
    task automatic send_request(input logic [1:0] act, input int first_pg, input int cnt);
        int gap;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action     = act;
        start_page = first_pg[IDX_W-1:0];
        req_pages  = cnt[CNT_W-1:0];
        in_valid   = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
    endtask

    // active_bytes is only rewritten with the block idle
    task automatic write_active_bytes(input int bytes);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = bytes[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // random request sized for the active page count
    // counts stay small most of the time; ranges lean toward the low pages
    // where single-page and run allocations land
    task automatic random_request(input int live);
        int         pick;
        int         cnt;
        int         first_pg;
        int         span;
        logic [1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_ALLOC_ONE;
        else if (pick < 60)
            act = ACT_ALLOC_RUN;
        else if (pick < 75)
            act = ACT_MARK;
        else
            act = ACT_FREE;
        span = (live < 24) ? live : 24;
        if (span < 1)
            span = 1;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            cnt = 0;
        else if (pick < 80)
            cnt = $urandom_range(1, span);
        else if (pick < 90)
            cnt = $urandom_range(1, (live > 0) ? live : 1);
        else if (pick < 96)
            cnt = live + $urandom_range(0, 1);  // whole map, or one page too many
        else
            cnt = $urandom_range(0, 32768);
        pick = $urandom_range(0, 99);
        if (cnt <= live && pick < 80)
        begin
            span = live - cnt;
            if (span > 255 && $urandom_range(0, 1) == 1)
                span = 255;
            first_pg = $urandom_range(0, span);
        end
        else if (pick < 90 && cnt <= live + 1)
            first_pg = live - cnt + 1;          // ends one page past the last active one
        else
            first_pg = $urandom_range(0, 32767);
        send_request(act, first_pg & 32'h7FFF, cnt);
    endtask

    // result side: random stall per beat, and one long hold-off
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = (beats_taken == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_gap(take_calm);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            beats_taken++;
        end
    end

    initial
    begin : stimulus
        int bytes;
        int live;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset setting (4096 bytes, 32768 pages);
        // in_ready stays low through the clearing pass, send_request just waits
        send_request(ACT_ALLOC_ONE, 0, 0);          // lowest free page
        send_request(ACT_ALLOC_RUN, 0, 0);          // zero count fails
        send_request(ACT_MARK, 5, 0);
        send_request(ACT_FREE, 5, 0);
        send_request(ACT_MARK, 32767, 1);           // last page of the map
        send_request(ACT_MARK, 32767, 2);           // past the end
        send_request(ACT_FREE, 0, 32769);
        send_request(ACT_MARK, 0, 32768);           // whole map used
        send_request(ACT_ALLOC_ONE, 0, 0);          // nothing free
        send_request(ACT_ALLOC_RUN, 0, 1);
        send_request(ACT_FREE, 32767, 1);
        send_request(ACT_ALLOC_ONE, 32767, 65535);  // widest page number, count ignored
        send_request(ACT_FREE, 32760, 8);
        send_request(ACT_ALLOC_RUN, 0, 8);          // run ending at the last page
        send_request(ACT_FREE, 0, 32768);
        send_request(ACT_MARK, 8, 8);               // full byte must split the run
        send_request(ACT_ALLOC_RUN, 0, 10);
        send_request(ACT_ALLOC_ONE, 0, 0);
        send_request(ACT_FREE, 0, 32);
        send_request(ACT_ALLOC_RUN, 0, 32768);      // run spanning the whole map
        send_request(ACT_FREE, 0, 32768);

        // no active bytes: every action fails
        write_active_bytes(0);
        send_request(ACT_ALLOC_ONE, 0, 1);
        send_request(ACT_ALLOC_RUN, 0, 1);
        send_request(ACT_MARK, 0, 1);
        send_request(ACT_FREE, 0, 1);

        // oversized setting behaves as the full map
        write_active_bytes(8191);
        send_request(ACT_MARK, 32767, 1);
        send_request(ACT_ALLOC_RUN, 0, 32768);
        send_request(ACT_FREE, 32767, 1);

        // random phases, one active_bytes setting each
        for (int i = 0; i < PHASES; i++)
        begin
            bytes = (plan_bytes[i] < 0) ? $urandom_range(1, 40) : plan_bytes[i];
            write_active_bytes(bytes);
            live = ((bytes > DEFAULT_BITMAP_BYTES) ? DEFAULT_BITMAP_BYTES : bytes) * 8;
            repeat (plan_items[i]) random_request(live);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin : watchdog
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_datapath.sv
rtl/core/bpa_ctrl.sv
rtl/core/bitmap_page_allocator.sv
verif/page_grant_check.sv
verif/tb_top.sv
